/* rtl/tlbq_pkg.sv */
`timescale 1ns / 1ps
// Package for the two-level byte quota block: sizes, operation and status
// codes, configuration register indexes and the word and control structs.
// Depends on nothing.
package tlbq_pkg;

  localparam int SLOT_COUNT = 16;
  localparam int SLOT_IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int CNT_W      = 32;

  localparam logic [1:0] FUNC_RESERVE = 2'd0;
  localparam logic [1:0] FUNC_RELEASE = 2'd1;
  localparam logic [1:0] FUNC_QUERY   = 2'd2;

  localparam logic [1:0] ST_OK          = 2'd0;
  localparam logic [1:0] ST_INVALID     = 2'd1;
  localparam logic [1:0] ST_CAPACITY    = 2'd2;
  localparam logic [1:0] ST_BAD_RELEASE = 2'd3;

  localparam logic [1:0] CFG_REQUEST_LIMIT = 2'd0;
  localparam logic [1:0] CFG_SLOT_LIMIT    = 2'd1;
  localparam logic [1:0] CFG_TOTAL_LIMIT   = 2'd2;

  typedef struct packed {
    logic [1:0]       func;
    logic [7:0]       slot;
    logic [CNT_W-1:0] amount;
  } in_word_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [CNT_W-1:0] slot_total;
    logic [CNT_W-1:0] overall_total;
  } out_word_t;

  typedef struct packed {
    logic [CNT_W-1:0] request;
    logic [CNT_W-1:0] slot;
    logic [CNT_W-1:0] total;
  } limits_t;

  typedef struct packed {
    logic             we;
    logic [CNT_W-1:0] slot_val;
    logic [CNT_W-1:0] total_val;
  } update_t;

endpackage

/* rtl/tlbq_eval.sv */
`timescale 1ns / 1ps
// Decision logic for one request: checks a reserve or release against the
// limits and the current counters and forms the result word and counter update.
// Depends on tlbq_pkg.
module tlbq_eval (
  input  tlbq_pkg::in_word_t         item,
  input  logic [tlbq_pkg::CNT_W-1:0] slot_cnt,
  input  logic [tlbq_pkg::CNT_W-1:0] total_cnt,
  input  tlbq_pkg::limits_t          limits,
  output tlbq_pkg::out_word_t        result,
  output tlbq_pkg::update_t          update
);

  logic                       in_range;
  logic [tlbq_pkg::CNT_W-1:0] cur;
  logic [tlbq_pkg::CNT_W:0]   slot_sum;
  logic [tlbq_pkg::CNT_W:0]   total_sum;
  logic                       amount_zero;
  logic [1:0]                 status;
  logic [tlbq_pkg::CNT_W-1:0] new_slot;
  logic [tlbq_pkg::CNT_W-1:0] new_total;
  logic                       we;

  assign in_range    = ({1'b0, item.slot} < 9'(tlbq_pkg::SLOT_COUNT));
  assign cur         = in_range ? slot_cnt : '0;
  assign amount_zero = (item.amount == '0);
  assign slot_sum    = {1'b0, cur} + {1'b0, item.amount};
  assign total_sum   = {1'b0, total_cnt} + {1'b0, item.amount};

  always_comb begin
    status    = tlbq_pkg::ST_OK;
    new_slot  = cur;
    new_total = total_cnt;
    we        = 1'b0;
    unique case (item.func)
      tlbq_pkg::FUNC_RESERVE: begin
        if (!in_range || amount_zero || (item.amount > limits.request)) begin
          status = tlbq_pkg::ST_INVALID;
        end else if ((slot_sum > {1'b0, limits.slot}) ||
                     (total_sum > {1'b0, limits.total})) begin
          status = tlbq_pkg::ST_CAPACITY;
        end else begin
          new_slot  = slot_sum[tlbq_pkg::CNT_W-1:0];
          new_total = total_sum[tlbq_pkg::CNT_W-1:0];
          we        = 1'b1;
        end
      end
      tlbq_pkg::FUNC_RELEASE: begin
        if (!in_range || amount_zero || (item.amount > cur) ||
            (item.amount > total_cnt)) begin
          status = tlbq_pkg::ST_BAD_RELEASE;
        end else begin
          new_slot  = cur - item.amount;
          new_total = total_cnt - item.amount;
          we        = 1'b1;
        end
      end
      tlbq_pkg::FUNC_QUERY: begin
        status = tlbq_pkg::ST_OK;
      end
      default: begin
        status = tlbq_pkg::ST_INVALID;
      end
    endcase
  end

  assign result.status        = status;
  assign result.slot_total    = in_range ? new_slot : '0;
  assign result.overall_total = new_total;

  assign update.we        = we;
  assign update.slot_val  = new_slot;
  assign update.total_val = new_total;

endmodule

/* rtl/two_level_byte_quota_core.sv */
`timescale 1ns / 1ps
// Top level of the two-level byte quota: input register, slot and total
// counters, limit registers and the result register.
// Depends on tlbq_pkg and tlbq_eval.
//
//   Channel  Ports                           Direction  Word
//   in       in_valid, in_ready, in_data     sink       tlbq_pkg::in_word_t
//   out      out_valid, out_ready, out_data  source     tlbq_pkg::out_word_t
//   cfg      cfg_we, cfg_idx, cfg_wdata      sink       32-bit limit register
//
// One word per cycle is sustained while out_ready is high; a word waits in the
// input register, then goes to the output register with the counter update.
// The decision for a word is one add and compare on its slot counter and the
// total, so the word that follows always sees the updated counters.
// Reset clears all counters to zero and sets every limit to all ones.
// When out_ready is low with the output full, in_ready drops once the input
// register is also full; nothing is lost or repeated.
module two_level_byte_quota_core (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  tlbq_pkg::in_word_t         in_data,
  output logic                       out_valid,
  input  logic                       out_ready,
  output tlbq_pkg::out_word_t        out_data,
  input  logic                       cfg_we,
  input  logic [1:0]                 cfg_idx,
  input  logic [tlbq_pkg::CNT_W-1:0] cfg_wdata
);

  logic                       s1_valid_r;
  logic                       s1_valid_nxt;
  tlbq_pkg::in_word_t         s1_item_r;
  logic                       out_valid_r;
  logic                       out_valid_nxt;
  tlbq_pkg::out_word_t        out_r;
  logic [tlbq_pkg::CNT_W-1:0] cnt_r [tlbq_pkg::SLOT_COUNT];
  logic [tlbq_pkg::CNT_W-1:0] total_r;
  tlbq_pkg::limits_t          limits_r;
  tlbq_pkg::limits_t          limits_nxt;

  logic                          in_fire;
  logic                          fire;
  logic [tlbq_pkg::SLOT_IDX_W-1:0] idx;
  logic [tlbq_pkg::CNT_W-1:0]    slot_rd;
  tlbq_pkg::out_word_t           result;
  tlbq_pkg::update_t             update;

  assign fire     = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || fire;
  assign in_fire  = in_valid && in_ready;

  assign idx     = s1_item_r.slot[tlbq_pkg::SLOT_IDX_W-1:0];
  assign slot_rd = cnt_r[idx];

  tlbq_eval u_eval (
    .item      (s1_item_r),
    .slot_cnt  (slot_rd),
    .total_cnt (total_r),
    .limits    (limits_r),
    .result    (result),
    .update    (update)
  );

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
    end else if (fire) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    limits_nxt = limits_r;
    if (cfg_we) begin
      unique case (cfg_idx)
        tlbq_pkg::CFG_REQUEST_LIMIT: limits_nxt.request = cfg_wdata;
        tlbq_pkg::CFG_SLOT_LIMIT:    limits_nxt.slot    = cfg_wdata;
        tlbq_pkg::CFG_TOTAL_LIMIT:   limits_nxt.total   = cfg_wdata;
        default:                     limits_nxt         = limits_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      total_r     <= '0;
      limits_r    <= '1;
      for (int i = 0; i < tlbq_pkg::SLOT_COUNT; i++) begin
        cnt_r[i] <= '0;
      end
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      limits_r    <= limits_nxt;
      if (fire && update.we) begin
        cnt_r[idx] <= update.slot_val;
        total_r    <= update.total_val;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_item_r <= in_data;
    end
    if (fire) begin
      out_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_refused_keeps_total: assert property (@(posedge clk) disable iff (!rst_n)
    fire && (result.status != tlbq_pkg::ST_OK) |=> $stable(total_r))
    else $error("refused request changed the total counter");

  a_reserve_adds: assert property (@(posedge clk) disable iff (!rst_n)
    fire && update.we && (s1_item_r.func == tlbq_pkg::FUNC_RESERVE)
    |=> total_r == $past(total_r) + $past(s1_item_r.amount))
    else $error("granted reserve did not add its amount to the total");

  a_slot_within_total: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r |-> (slot_rd <= total_r))
    else $error("slot counter exceeds the total counter");

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && out_valid_r && !out_ready |-> !in_ready)
    else $error("input accepted while both registers are held");

endmodule

/* dv/tlbq_tb_pkg.sv */
`timescale 1ns / 1ps
// Scoreboard for the two-level byte quota testbench: keeps its own limits and
// counters, predicts the reply to each accepted word and checks replies in order.
// Depends on tlbq_pkg.
package tlbq_tb_pkg;
  import tlbq_pkg::*;

  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam logic [1:0] CFG_UNUSED  = 2'd3;

  class quota_ledger;
    logic [CNT_W-1:0] request_cap;
    logic [CNT_W-1:0] slot_cap;
    logic [CNT_W-1:0] total_cap;
    logic [CNT_W-1:0] slot_bytes[SLOT_COUNT];
    logic [CNT_W-1:0] total_bytes;
    out_word_t        pending_replies[$];
    int               mismatches;

    function new();
      request_cap = '1;
      slot_cap    = '1;
      total_cap   = '1;
      foreach (slot_bytes[i]) slot_bytes[i] = '0;
      total_bytes = '0;
      mismatches  = 0;
    endfunction

    function void set_limit(logic [1:0] idx, logic [CNT_W-1:0] value);
      case (idx)
        CFG_REQUEST_LIMIT: request_cap = value;
        CFG_SLOT_LIMIT:    slot_cap    = value;
        CFG_TOTAL_LIMIT:   total_cap   = value;
        default: ;
      endcase
    endfunction

    function logic [CNT_W-1:0] slot_level(logic [7:0] slot);
      return (slot < SLOT_COUNT) ? slot_bytes[slot] : '0;
    endfunction

    function int outstanding();
      return pending_replies.size();
    endfunction

    function out_word_t predict_reply(in_word_t w);
      out_word_t      r;
      logic           in_range;
      logic [CNT_W:0] slot_sum;
      logic [CNT_W:0] total_sum;
      in_range = (w.slot < SLOT_COUNT);
      r.status = ST_OK;
      case (w.func)
        FUNC_RESERVE: begin
          if (!in_range || w.amount == '0 || w.amount > request_cap) begin
            r.status = ST_INVALID;
          end else begin
            slot_sum  = {1'b0, slot_bytes[w.slot]} + w.amount;
            total_sum = {1'b0, total_bytes} + w.amount;
            if (slot_sum > {1'b0, slot_cap} || total_sum > {1'b0, total_cap}) begin
              r.status = ST_CAPACITY;
            end else begin
              slot_bytes[w.slot] = slot_sum[CNT_W-1:0];
              total_bytes        = total_sum[CNT_W-1:0];
            end
          end
        end
        FUNC_RELEASE: begin
          if (!in_range || w.amount == '0 || w.amount > slot_level(w.slot) ||
              w.amount > total_bytes) begin
            r.status = ST_BAD_RELEASE;
          end else begin
            slot_bytes[w.slot] = slot_bytes[w.slot] - w.amount;
            total_bytes        = total_bytes - w.amount;
          end
        end
        FUNC_QUERY: ;
        default: r.status = ST_INVALID;
      endcase
      r.slot_total    = slot_level(w.slot);
      r.overall_total = total_bytes;
      return r;
    endfunction

    function void note_request(in_word_t w);
      pending_replies.push_back(predict_reply(w));
    endfunction

    function void check_reply(out_word_t got);
      out_word_t want;
      if (pending_replies.size() == 0) begin
        mismatches++;
        $display("%0t: reply with none expected: status=%0d slot_total=%h overall_total=%h",
                 $time, got.status, got.slot_total, got.overall_total);
        return;
      end
      want = pending_replies.pop_front();
      if (got.status !== want.status || got.slot_total !== want.slot_total ||
          got.overall_total !== want.overall_total) begin
        mismatches++;
        $display("%0t: reply mismatch: expected status=%0d slot_total=%h overall_total=%h",
                 $time, want.status, want.slot_total, want.overall_total);
        $display("%0t:                 actual   status=%0d slot_total=%h overall_total=%h",
                 $time, got.status, got.slot_total, got.overall_total);
      end
    endfunction
  endclass

endpackage

/* dv/two_level_byte_quota_core_tb.sv */
`timescale 1ns / 1ps
// Testbench for two_level_byte_quota_core: directed and random reserve, release
// and query words under several limit settings, with random stalls on both sides.
// Depends on tlbq_pkg, tlbq_tb_pkg and the block's RTL.
module two_level_byte_quota_core_tb;
  import tlbq_pkg::*;
  import tlbq_tb_pkg::*;

  localparam int HOLD_CYCLES = 300;
  localparam int QUIET_LIMIT = 4000;
  localparam int PHASES      = 8;
  localparam int PHASE_WORDS = 240;

  logic             clk       = 1'b0;
  logic             rst_n     = 1'b0;
  logic             in_valid  = 1'b0;
  logic             in_ready;
  in_word_t         in_data   = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  out_word_t        out_data;
  logic             cfg_we    = 1'b0;
  logic [1:0]       cfg_idx   = CFG_REQUEST_LIMIT;
  logic [CNT_W-1:0] cfg_wdata = '0;

  quota_ledger ledger;
  bit          tx_gaps  = 1'b0;
  bit          rx_gaps  = 1'b0;
  bit          hold_req = 1'b0;
  int          quiet_cycles = 0;

  always #6 clk = ~clk;

  two_level_byte_quota_core u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  initial begin : receiver
    int hold_left;
    int gap_left;
    hold_left = 0;
    gap_left  = 0;
    wait (rst_n);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else if (gap_left > 0) begin
        out_ready <= 1'b0;
        gap_left--;
      end else if (rx_gaps && $urandom_range(0, 7) == 0) begin
        out_ready <= 1'b0;
        gap_left = $urandom_range(1, 11) - 1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) ledger.check_reply(out_data);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("two_level_byte_quota_core test failed");
        $finish;
      end
    end
  end

  task automatic send_word(in_word_t w);
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (!in_ready);
    ledger.note_request(w);
  endtask

  task automatic send_op(logic [1:0] func, logic [7:0] slot, logic [CNT_W-1:0] amount);
    in_word_t w;
    w.func   = func;
    w.slot   = slot;
    w.amount = amount;
    send_word(w);
  endtask

  task automatic sender_gap(int cycles);
    @(negedge clk);
    in_valid <= 1'b0;
    repeat (cycles - 1) @(negedge clk);
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (ledger.outstanding() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_limit(logic [1:0] idx, logic [CNT_W-1:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    ledger.set_limit(idx, value);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_limits(logic [CNT_W-1:0] req, logic [CNT_W-1:0] slot,
                            logic [CNT_W-1:0] total);
    write_limit(CFG_REQUEST_LIMIT, req);
    write_limit(CFG_SLOT_LIMIT, slot);
    write_limit(CFG_TOTAL_LIMIT, total);
  endtask

  // Amounts lean toward values that land on or just past a limit or a counter.
  function automatic in_word_t random_word();
    in_word_t         w;
    logic [CNT_W-1:0] level;
    logic [CNT_W-1:0] modest;
    int               pick;
    pick   = $urandom_range(0, 99);
    w.func = (pick < 40) ? FUNC_RESERVE :
             (pick < 72) ? FUNC_RELEASE :
             (pick < 94) ? FUNC_QUERY : FUNC_UNUSED;
    w.slot = ($urandom_range(0, 9) != 0) ? 8'($urandom_range(0, SLOT_COUNT - 1)) :
                                           8'($urandom_range(SLOT_COUNT, 255));
    level  = ledger.slot_level(w.slot);
    modest = (ledger.request_cap == '0 || ledger.request_cap > 5000) ? 5000 :
             ledger.request_cap;
    pick   = $urandom_range(0, 9);
    if (w.func == FUNC_RESERVE) begin
      case (pick)
        0:       w.amount = '0;
        1:       w.amount = $urandom;
        2:       w.amount = ledger.request_cap;
        3:       w.amount = ledger.request_cap + 1;
        4:       w.amount = ledger.slot_cap - level;
        5:       w.amount = ledger.total_cap - ledger.total_bytes;
        default: w.amount = $urandom_range(1, modest);
      endcase
    end else if (w.func == FUNC_RELEASE) begin
      case (pick)
        0:       w.amount = '0;
        1:       w.amount = $urandom;
        2:       w.amount = level;
        3:       w.amount = level + 1;
        4:       w.amount = ledger.total_bytes;
        default: w.amount = (level == '0) ? $urandom_range(1, 100) : $urandom_range(1, level);
      endcase
    end else begin
      w.amount = $urandom;
    end
    return w;
  endfunction

  initial begin : stimulus
    ledger = new();
    repeat (8) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    send_op(FUNC_QUERY, 8'd0, '0);
    send_op(FUNC_QUERY, 8'hFF, '1);
    send_op(FUNC_RESERVE, 8'(SLOT_COUNT), 32'd5);
    send_op(FUNC_RESERVE, 8'd3, '0);
    send_op(FUNC_RESERVE, 8'd0, '1);
    send_op(FUNC_RESERVE, 8'd1, 32'd1);
    send_op(FUNC_RELEASE, 8'd1, 32'd1);
    send_op(FUNC_RELEASE, 8'd0, '0);
    send_op(FUNC_RELEASE, 8'hFF, 32'd1);
    send_op(FUNC_RELEASE, 8'd0, '1);
    send_op(FUNC_UNUSED, 8'd15, 32'd5);
    send_op(FUNC_RESERVE, 8'd15, 32'h8000_0000);
    send_op(FUNC_UNUSED, 8'd200, '0);
    send_op(FUNC_QUERY, 8'd15, 32'h1234);
    send_op(FUNC_RELEASE, 8'd15, 32'h8000_0000);
    drain();
    set_limits(32'd10, 32'd20, 32'd30);
    write_limit(CFG_UNUSED, '0);
    send_op(FUNC_RESERVE, 8'd2, 32'd11);
    send_op(FUNC_RESERVE, 8'd2, 32'd10);
    send_op(FUNC_RESERVE, 8'd2, 32'd10);
    send_op(FUNC_RESERVE, 8'd2, 32'd1);
    send_op(FUNC_RESERVE, 8'd3, 32'd10);
    send_op(FUNC_RESERVE, 8'd4, 32'd1);
    drain();
    // The total limit now sits below the bytes already held.
    write_limit(CFG_TOTAL_LIMIT, 32'd5);
    send_op(FUNC_RESERVE, 8'd5, 32'd1);
    send_op(FUNC_RELEASE, 8'd2, 32'd20);
    send_op(FUNC_RELEASE, 8'd3, 32'd11);

    for (int p = 0; p < PHASES; p++) begin
      drain();
      case (p)
        0:       set_limits('1, '1, '1);
        1:       set_limits('0, $urandom, $urandom);
        2:       set_limits(32'd500, 32'd2000, 32'd6000);
        3:       set_limits('1, '0, '1);
        4:       set_limits(32'd64, 32'd300, '0);
        5:       set_limits($urandom, $urandom, $urandom);
        6:       set_limits(32'd1000, 32'd4000, 32'd20000);
        default: set_limits('1, 32'h8000_0000, 32'hC000_0000);
      endcase
      for (int n = 0; n < PHASE_WORDS; n++) begin
        if (n % 40 == 0) begin
          tx_gaps = (p < PHASES - 1) && ($urandom_range(0, 2) != 0);
          rx_gaps = (p < PHASES - 1) && ($urandom_range(0, 2) != 0);
        end
        // Long receiver stall while words keep coming, so the input backs up.
        if (p == 2 && n == 0) begin
          tx_gaps  = 1'b0;
          hold_req = 1'b1;
        end
        if (p == 4 && n == PHASE_WORDS / 2) drain();
        send_word(random_word());
        if (tx_gaps && $urandom_range(0, 7) == 0) sender_gap($urandom_range(1, 11));
      end
    end

    drain();
    repeat (8) @(posedge clk);
    if (ledger.mismatches == 0 && ledger.outstanding() == 0) begin
      $display("two_level_byte_quota_core test passed");
    end else begin
      $display("two_level_byte_quota_core test failed");
    end
    $finish;
  end

endmodule
